/* sv/life_generation_word_stream_assert.svh */
// Assertion macros for the block's top module.
`ifndef LIFE_GENERATION_WORD_STREAM_ASSERT_SVH
`define LIFE_GENERATION_WORD_STREAM_ASSERT_SVH

`ifndef ASSERT_OFF

`define LGWS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lgws: same-cycle check failed");

`define LGWS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lgws: next-cycle check failed");

`else

`define LGWS_ASSERT_IMP(label, clk, rst_n, pre, post)
`define LGWS_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

/* sv/lgws_pkg.sv */
package lgws_pkg;

    localparam int WORD_BITS  = 64;
    localparam int TOP_BIT    = 63;
    localparam int ROW_OUT_W  = 9;
    localparam int WORD_OUT_W = 4;

    // Row of a tap relative to the result row
    localparam logic [1:0] ROW_ABOVE = 2'd0;
    localparam logic [1:0] ROW_MID   = 2'd1;
    localparam logic [1:0] ROW_BELOW = 2'd2;

    // Word of a tap relative to the result word
    localparam logic [1:0] COL_WEST = 2'd0;
    localparam logic [1:0] COL_MID  = 2'd1;
    localparam logic [1:0] COL_EAST = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LAND,
        S_EMIT
    } state_t;

    // One read of the row memory as it lands in the window
    typedef struct packed {
        logic       valid;
        logic       live;
        logic [1:0] row;
        logic [1:0] col;
    } tap_t;

endpackage

/* sv/lgws_ram.sv */
module lgws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lgws_calc.sv */
module lgws_calc (
    input  logic                              clk,
    input  lgws_pkg::tap_t                    land,
    input  logic [lgws_pkg::WORD_BITS-1:0]    rdata,
    output logic [lgws_pkg::WORD_BITS-1:0]    next_word
);

    localparam int WB = lgws_pkg::WORD_BITS;
    localparam int TB = lgws_pkg::TOP_BIT;

    // 3x3 window: full centre words, one edge bit from each side word
    logic [WB-1:0] centre_reg [3];
    logic [2:0]    west_reg;
    logic [2:0]    east_reg;

    logic [WB-1:0] land_word;
    logic [WB-1:0] nb [8];
    logic [WB-1:0] c0, c1, c2, c3, carry, t;

    // Cells beyond the grid read as dead
    assign land_word = land.live ? rdata : '0;

    always_ff @(posedge clk)
    begin
        if (land.valid)
        begin
            case (land.col)
                lgws_pkg::COL_WEST: west_reg[land.row]   <= land_word[TB];
                lgws_pkg::COL_MID:  centre_reg[land.row] <= land_word;
                lgws_pkg::COL_EAST: east_reg[land.row]   <= land_word[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        nb[0] = {centre_reg[lgws_pkg::ROW_ABOVE][TB-1:0], west_reg[lgws_pkg::ROW_ABOVE]};
        nb[1] = centre_reg[lgws_pkg::ROW_ABOVE];
        nb[2] = {east_reg[lgws_pkg::ROW_ABOVE], centre_reg[lgws_pkg::ROW_ABOVE][TB:1]};
        nb[3] = {centre_reg[lgws_pkg::ROW_MID][TB-1:0], west_reg[lgws_pkg::ROW_MID]};
        nb[4] = {east_reg[lgws_pkg::ROW_MID], centre_reg[lgws_pkg::ROW_MID][TB:1]};
        nb[5] = {centre_reg[lgws_pkg::ROW_BELOW][TB-1:0], west_reg[lgws_pkg::ROW_BELOW]};
        nb[6] = centre_reg[lgws_pkg::ROW_BELOW];
        nb[7] = {east_reg[lgws_pkg::ROW_BELOW], centre_reg[lgws_pkg::ROW_BELOW][TB:1]};

        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        // Bit-sliced ripple counter, one neighbour word per step
        for (int k = 0; k < 8; k++)
        begin
            carry = nb[k];
            t = c0 & carry; c0 = c0 ^ carry; carry = t;
            t = c1 & carry; c1 = c1 ^ carry; carry = t;
            t = c2 & carry; c2 = c2 ^ carry; carry = t;
            c3 = c3 ^ carry;
        end

        // Count of 2 or 3: born on 3, survive on 2
        t = c1 & ~c2 & ~c3;
        next_word = (c0 & t) | (centre_reg[lgws_pkg::ROW_MID] & ~c0 & t);
    end

endmodule

/* sv/life_generation_word_stream.sv */
// One Life generation (B3/S23) over a grid streamed as 64-bit words in raster order.
// Input channel: cell_word with in_valid / in_stall; a word is taken when in_valid
// is high and in_stall low. Output channel: next_cells, out_row, out_word,
// run_last and frame_done with out_valid / out_stall.
// Row r word i comes out once row r+1 word i+1 has been taken; the last word of a
// row also releases the previous row's last word, and the final word of the grid
// releases the whole last row. run_last marks the last result of an input word,
// frame_done the last result of the generation.
// Each result takes nine window reads through the single read port of the row
// memory, a state for the last read to land, and one to register the result.
// A word that releases no result is taken while the sequencer stays idle; one that
// releases results stalls the input until its last result is loaded; the final
// word of the grid releases WORDS_PER_ROW + 2 results.
// Reset clears the row and word counters and out_valid; the result register and
// the row memory are not cleared, and the row memory needs no clearing pass.
// While out_stall is high the finished result holds and the sequencer waits
// before loading the next one; input words are taken only while the sequencer
// is idle, so a held result backs up into the input.
`include "life_generation_word_stream_assert.svh"

module life_generation_word_stream #(
    parameter int WORDS_PER_ROW = 16,
    parameter int GRID_ROWS     = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] cell_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] next_cells,
    output logic [8:0]  out_row,
    output logic [3:0]  out_word,
    output logic        run_last,
    output logic        frame_done
);

    localparam int WB         = lgws_pkg::WORD_BITS;
    localparam int OUT_ROW_W  = lgws_pkg::ROW_OUT_W;
    localparam int OUT_WORD_W = lgws_pkg::WORD_OUT_W;
    localparam int WORD_IDX_W = $clog2(WORDS_PER_ROW);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int RAM_DEPTH  = 3 * WORDS_PER_ROW;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);

    localparam logic [ADDR_W-1:0]     BASE_1    = ADDR_W'(WORDS_PER_ROW);
    localparam logic [ADDR_W-1:0]     BASE_2    = ADDR_W'(2 * WORDS_PER_ROW);
    localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(WORDS_PER_ROW - 1);
    localparam logic [ROW_W-1:0]      ROW_LAST  = ROW_W'(GRID_ROWS - 1);

    function automatic logic [1:0] slot_up(input logic [1:0] s);
        slot_up = (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_down(input logic [1:0] s);
        slot_down = (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] s);
        case (s)
            2'd0:    slot_base = '0;
            2'd1:    slot_base = BASE_1;
            default: slot_base = BASE_2;
        endcase
    endfunction

    lgws_pkg::state_t state_reg, state_next;

    logic [ROW_W-1:0]      in_row_reg, in_row_next;
    logic [WORD_IDX_W-1:0] in_word_reg, in_word_next;
    logic [1:0]            in_slot_reg, in_slot_next;

    logic [ROW_W-1:0]      job_row_reg, job_row_next;
    logic [1:0]            job_slot_reg, job_slot_next;
    logic [WORD_IDX_W-1:0] job_word_reg, job_word_next;
    logic [WORD_IDX_W-1:0] job_end_reg, job_end_next;
    logic                  tail_reg, tail_next;
    logic                  frame_job_reg, frame_job_next;

    logic [1:0]            tap_row_reg, tap_row_next;
    logic [1:0]            tap_col_reg, tap_col_next;
    lgws_pkg::tap_t        land_reg, land_next;

    logic                  out_valid_reg;
    logic [WB-1:0]         next_cells_reg;
    logic [OUT_ROW_W-1:0]  out_row_reg;
    logic [OUT_WORD_W-1:0] out_word_reg;
    logic                  run_last_reg;
    logic                  frame_done_reg;

    logic                  in_acc;
    logic                  row_end;
    logic                  frame_end;
    logic                  has_prev;
    logic                  job_done;
    logic                  out_free;
    logic                  load_out;
    logic                  tap_last;
    logic                  tap_live;
    logic [1:0]            tap_slot;
    logic [WORD_IDX_W-1:0] tap_word;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WB-1:0]         ram_rdata;
    logic [WB-1:0]         calc_word;

    lgws_ram #(
        .WIDTH (WB),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cell_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lgws_calc u_calc (
        .clk       (clk),
        .land      (land_reg),
        .rdata     (ram_rdata),
        .next_word (calc_word)
    );

    assign row_end   = (in_word_reg == WORD_LAST);
    assign frame_end = row_end && (in_row_reg == ROW_LAST);
    assign has_prev  = (in_row_reg != '0) && (in_word_reg != '0);
    assign job_done  = (job_word_reg == job_end_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign tap_last  = (tap_row_reg == lgws_pkg::ROW_BELOW) && (tap_col_reg == lgws_pkg::COL_EAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgws_pkg::S_IDLE:
            begin
                if (in_valid && has_prev)
                begin
                    state_next = lgws_pkg::S_READ;
                end
            end
            lgws_pkg::S_READ:
            begin
                if (tap_last)
                begin
                    state_next = lgws_pkg::S_LAND;
                end
            end
            lgws_pkg::S_LAND:
            begin
                state_next = lgws_pkg::S_EMIT;
            end
            lgws_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (job_done && !tail_reg) ? lgws_pkg::S_IDLE
                                                         : lgws_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = lgws_pkg::S_IDLE;
            end
        endcase
    end

    // Tap address and range check
    always_comb
    begin
        case (tap_row_reg)
            lgws_pkg::ROW_ABOVE: tap_slot = slot_down(job_slot_reg);
            lgws_pkg::ROW_MID:   tap_slot = job_slot_reg;
            default:             tap_slot = slot_up(job_slot_reg);
        endcase
        case (tap_col_reg)
            lgws_pkg::COL_WEST: tap_word = job_word_reg - WORD_IDX_W'(1);
            lgws_pkg::COL_MID:  tap_word = job_word_reg;
            default:            tap_word = job_word_reg + WORD_IDX_W'(1);
        endcase
        tap_live = 1'b1;
        if (tap_row_reg == lgws_pkg::ROW_ABOVE && job_row_reg == '0)
        begin
            tap_live = 1'b0;
        end
        if (tap_row_reg == lgws_pkg::ROW_BELOW && job_row_reg == ROW_LAST)
        begin
            tap_live = 1'b0;
        end
        if (tap_col_reg == lgws_pkg::COL_WEST && job_word_reg == '0)
        begin
            tap_live = 1'b0;
        end
        if (tap_col_reg == lgws_pkg::COL_EAST && job_word_reg == WORD_LAST)
        begin
            tap_live = 1'b0;
        end
    end

    // Outputs and datapath control
    always_comb
    begin
        in_stall = (state_reg != lgws_pkg::S_IDLE);
        in_acc   = in_valid && (state_reg == lgws_pkg::S_IDLE);
        load_out = (state_reg == lgws_pkg::S_EMIT) && out_free;

        ram_we    = in_acc;
        ram_waddr = slot_base(in_slot_reg) + ADDR_W'(in_word_reg);
        ram_re    = (state_reg == lgws_pkg::S_READ) && tap_live;
        ram_raddr = slot_base(tap_slot) + ADDR_W'(tap_word);

        land_next.valid = (state_reg == lgws_pkg::S_READ);
        land_next.live  = tap_live;
        land_next.row   = tap_row_reg;
        land_next.col   = tap_col_reg;

        in_row_next  = in_row_reg;
        in_word_next = in_word_reg;
        in_slot_next = in_slot_reg;
        if (in_acc)
        begin
            if (row_end)
            begin
                in_word_next = '0;
                in_row_next  = frame_end ? '0 : in_row_reg + ROW_W'(1);
                in_slot_next = frame_end ? 2'd0 : slot_up(in_slot_reg);
            end
            else
            begin
                in_word_next = in_word_reg + WORD_IDX_W'(1);
            end
        end

        job_row_next   = job_row_reg;
        job_slot_next  = job_slot_reg;
        job_word_next  = job_word_reg;
        job_end_next   = job_end_reg;
        tail_next      = tail_reg;
        frame_job_next = frame_job_reg;
        if (in_acc && has_prev)
        begin
            // Previous row, one word behind; at row end also its last word
            job_row_next   = in_row_reg - ROW_W'(1);
            job_slot_next  = slot_down(in_slot_reg);
            job_word_next  = in_word_reg - WORD_IDX_W'(1);
            job_end_next   = row_end ? in_word_reg : in_word_reg - WORD_IDX_W'(1);
            tail_next      = frame_end;
            frame_job_next = 1'b0;
        end
        else if (load_out)
        begin
            if (!job_done)
            begin
                job_word_next = job_word_reg + WORD_IDX_W'(1);
            end
            else if (tail_reg)
            begin
                // Flush the whole last row
                job_row_next   = job_row_reg + ROW_W'(1);
                job_slot_next  = slot_up(job_slot_reg);
                job_word_next  = '0;
                job_end_next   = WORD_LAST;
                tail_next      = 1'b0;
                frame_job_next = 1'b1;
            end
        end

        tap_row_next = tap_row_reg;
        tap_col_next = tap_col_reg;
        if (state_reg == lgws_pkg::S_READ)
        begin
            if (tap_col_reg == lgws_pkg::COL_EAST)
            begin
                tap_col_next = lgws_pkg::COL_WEST;
                tap_row_next = tap_row_reg + 2'd1;
            end
            else
            begin
                tap_col_next = tap_col_reg + 2'd1;
            end
        end
        else
        begin
            tap_row_next = lgws_pkg::ROW_ABOVE;
            tap_col_next = lgws_pkg::COL_WEST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgws_pkg::S_IDLE;
            in_row_reg    <= '0;
            in_word_reg   <= '0;
            in_slot_reg   <= 2'd0;
            job_row_reg   <= '0;
            job_slot_reg  <= 2'd0;
            job_word_reg  <= '0;
            job_end_reg   <= '0;
            tail_reg      <= 1'b0;
            frame_job_reg <= 1'b0;
            tap_row_reg   <= lgws_pkg::ROW_ABOVE;
            tap_col_reg   <= lgws_pkg::COL_WEST;
            land_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_row_reg    <= in_row_next;
            in_word_reg   <= in_word_next;
            in_slot_reg   <= in_slot_next;
            job_row_reg   <= job_row_next;
            job_slot_reg  <= job_slot_next;
            job_word_reg  <= job_word_next;
            job_end_reg   <= job_end_next;
            tail_reg      <= tail_next;
            frame_job_reg <= frame_job_next;
            tap_row_reg   <= tap_row_next;
            tap_col_reg   <= tap_col_next;
            land_reg      <= land_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word; holds while stalled
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            next_cells_reg <= calc_word;
            out_row_reg    <= OUT_ROW_W'(job_row_reg);
            out_word_reg   <= OUT_WORD_W'(job_word_reg);
            run_last_reg   <= job_done && !tail_reg;
            frame_done_reg <= job_done && frame_job_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_cells = next_cells_reg;
    assign out_row    = out_row_reg;
    assign out_word   = out_word_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

    `LGWS_ASSERT_IMP(a_frame_is_last, clk, rst_n, out_valid_reg && frame_done_reg, run_last_reg)
    `LGWS_ASSERT_IMP(a_load_when_free, clk, rst_n, load_out, !out_valid_reg || !out_stall)
    `LGWS_ASSERT_NEXT(a_frame_wrap, clk, rst_n, in_acc && frame_end, in_row_reg == '0 && in_word_reg == '0)
    `LGWS_ASSERT_IMP(a_job_in_order, clk, rst_n, state_reg != lgws_pkg::S_IDLE, job_word_reg <= job_end_reg)

endmodule

/* dv/lgws_generation_check.sv */
`timescale 1ns / 1ps

module lgws_generation_check
    import lgws_pkg::*;
#(
    parameter int WORDS_PER_ROW = 16,
    parameter int GRID_ROWS     = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [WORD_BITS-1:0]  cell_word,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [WORD_BITS-1:0]  next_cells,
    input  logic [ROW_OUT_W-1:0]  out_row,
    input  logic [WORD_OUT_W-1:0] out_word,
    input  logic                  run_last,
    input  logic                  frame_done,
    output int                    faults,
    output int                    queued
);

    typedef struct packed {
        logic [WORD_BITS-1:0]  cells;
        logic [ROW_OUT_W-1:0]  row;
        logic [WORD_OUT_W-1:0] word;
        logic                  ends_run;
        logic                  ends_frame;
    } gen_word_t;

    // Three most recent rows, indexed by row modulo three
    logic [WORD_BITS-1:0] window_rows [3][WORDS_PER_ROW];
    int                   row_at;
    int                   word_at;
    gen_word_t            next_gen_due [$];
    int                   fault_total;
    int                   due_count;

    assign faults = fault_total;
    assign queued = due_count;

    initial
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int w = 0; w < WORDS_PER_ROW; w++)
            begin
                window_rows[r][w] = '0;
            end
        end
        row_at      = 0;
        word_at     = 0;
        fault_total = 0;
        due_count   = 0;
    end

    task automatic report(input string note);
        fault_total++;
        $display("%0t mismatch: %s", $time, note);
    endtask

    // Cells beyond any grid edge are dead
    function automatic logic [WORD_BITS-1:0] stored(input int row, input int word);
        if (row < 0 || row >= GRID_ROWS || word < 0 || word >= WORDS_PER_ROW)
        begin
            return '0;
        end
        return window_rows[row % 3][word];
    endfunction

    function automatic logic [WORD_BITS-1:0] evolve(input int row, input int word);
        logic [WORD_BITS+1:0] band [3];
        logic [WORD_BITS-1:0] west_w;
        logic [WORD_BITS-1:0] mid_w;
        logic [WORD_BITS-1:0] east_w;
        logic [WORD_BITS-1:0] fresh;
        int                   live;
        int                   d;
        int                   k;
        for (d = 0; d < 3; d++)
        begin
            west_w  = stored(row - 1 + d, word - 1);
            mid_w   = stored(row - 1 + d, word);
            east_w  = stored(row - 1 + d, word + 1);
            // pad with the neighbouring cells of the adjacent words
            band[d] = {east_w[0], mid_w, west_w[TOP_BIT]};
        end
        for (k = 0; k < WORD_BITS; k++)
        begin
            live = band[0][k] + band[0][k+1] + band[0][k+2]
                 + band[1][k] + band[1][k+2]
                 + band[2][k] + band[2][k+1] + band[2][k+2];
            fresh[k] = (live == 3) || (live == 2 && band[1][k+1]);
        end
        return fresh;
    endfunction

    task automatic take_cells(input logic [WORD_BITS-1:0] cells);
        int        r;
        int        c;
        int        n;
        int        j;
        int        rows_due [$];
        int        words_due [$];
        bit        row_end;
        bit        frame_end;
        gen_word_t g;
        r         = row_at;
        c         = word_at;
        row_end   = (c == WORDS_PER_ROW - 1);
        frame_end = row_end && (r == GRID_ROWS - 1);
        window_rows[r % 3][c] = cells;
        if (r >= 1 && c >= 1)
        begin
            rows_due.push_back(r - 1);
            words_due.push_back(c - 1);
        end
        if (r >= 1 && row_end)
        begin
            rows_due.push_back(r - 1);
            words_due.push_back(c);
        end
        // flush the whole last row on the final word of the grid
        if (frame_end)
        begin
            for (j = 0; j < WORDS_PER_ROW; j++)
            begin
                rows_due.push_back(r);
                words_due.push_back(j);
            end
        end
        n = rows_due.size();
        for (j = 0; j < n; j++)
        begin
            g.cells      = evolve(rows_due[j], words_due[j]);
            g.row        = ROW_OUT_W'(rows_due[j]);
            g.word       = WORD_OUT_W'(words_due[j]);
            g.ends_run   = (j == n - 1);
            g.ends_frame = frame_end && (j == n - 1);
            next_gen_due.push_back(g);
        end
        if (row_end)
        begin
            word_at = 0;
            row_at  = frame_end ? 0 : r + 1;
        end
        else
        begin
            word_at = c + 1;
        end
    endtask

    always @(posedge clk)
    begin : watch
        gen_word_t want;
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (next_gen_due.size() == 0)
                begin
                    report($sformatf("result row %0d word %0d with none expected",
                                     out_row, out_word));
                end
                else
                begin
                    want = next_gen_due.pop_front();
                    if (next_cells !== want.cells)
                    begin
                        report($sformatf("next_cells row %0d word %0d: got %h want %h",
                                         want.row, want.word, next_cells, want.cells));
                    end
                    if (out_row !== want.row)
                    begin
                        report($sformatf("out_row: got %0d want %0d", out_row, want.row));
                    end
                    if (out_word !== want.word)
                    begin
                        report($sformatf("out_word row %0d: got %0d want %0d",
                                         want.row, out_word, want.word));
                    end
                    if (run_last !== want.ends_run)
                    begin
                        report($sformatf("run_last row %0d word %0d: got %b want %b",
                                         want.row, want.word, run_last, want.ends_run));
                    end
                    if (frame_done !== want.ends_frame)
                    begin
                        report($sformatf("frame_done row %0d word %0d: got %b want %b",
                                         want.row, want.word, frame_done, want.ends_frame));
                    end
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                take_cells(cell_word);
            end
            due_count = next_gen_due.size();
        end
    end

endmodule

/* dv/life_generation_word_stream_test.sv */
`timescale 1ns / 1ps

module life_generation_word_stream_test;
    import lgws_pkg::*;

    localparam int WORDS_PER_ROW   = 16;
    localparam int GRID_ROWS       = 512;
    localparam int TOTAL_WORDS     = 330;
    localparam int QUIET_WORDS     = 60;
    localparam int HOLD_OFF_AT     = 120;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int OPENING_COUNT   = 25;

    // Row 0 then the start of row 1: grid edges, carries across word
    // boundaries, solid and empty words, small still lifes and oscillators
    localparam logic [WORD_BITS-1:0] OPENING [OPENING_COUNT] = '{
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555, 64'h0000_0000_0000_0007,
        64'hE000_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'hFFFF_0000_0000_FFFF, 64'h0000_0018_1800_0000,
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0001,
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h0000_0000_0000_0003, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0002,
        64'h0000_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0018_1800_0000, 64'h8000_0000_0000_0001,
        64'h5555_5555_5555_5555
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [WORD_BITS-1:0]  cell_word;
    logic                  out_valid;
    logic                  out_stall;
    logic [WORD_BITS-1:0]  next_cells;
    logic [ROW_OUT_W-1:0]  out_row;
    logic [WORD_OUT_W-1:0] out_word;
    logic                  run_last;
    logic                  frame_done;
    int                    faults;
    int                    queued;
    int                    sent_words;
    int                    cycles;

    life_generation_word_stream #(
        .WORDS_PER_ROW (WORDS_PER_ROW),
        .GRID_ROWS     (GRID_ROWS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_word  (cell_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_cells (next_cells),
        .out_row    (out_row),
        .out_word   (out_word),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    lgws_generation_check #(
        .WORDS_PER_ROW (WORDS_PER_ROW),
        .GRID_ROWS     (GRID_ROWS)
    ) gen_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_word  (cell_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_cells (next_cells),
        .out_row    (out_row),
        .out_word   (out_word),
        .run_last   (run_last),
        .frame_done (frame_done),
        .faults     (faults),
        .queued     (queued)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mix of empty, solid, sparse, dense and uniform words
    function automatic logic [WORD_BITS-1:0] random_cells();
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return a & b & c;
            4, 5: return a | b;
            default: return a;
        endcase
    endfunction

    initial
    begin
        int                   gap;
        int                   gap_pct;
        int                   phase_left;
        logic [WORD_BITS-1:0] cells;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cell_word  <= '0;
        sent_words = 0;
        gap_pct    = 0;
        phase_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < TOTAL_WORDS; i++)
        begin
            cells = (i < OPENING_COUNT) ? OPENING[i] : random_cells();
            if (phase_left == 0)
            begin
                gap_pct    = $urandom_range(0, 1) ? 25 : 0;
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            gap = 0;
            if (i < TOTAL_WORDS - QUIET_WORDS && $urandom_range(0, 99) < gap_pct)
            begin
                gap = $urandom_range(1, 8);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // hold the word until it is taken
            in_valid  <= 1'b1;
            cell_word <= cells;
            @(posedge clk);
            while (in_stall !== 1'b0) @(posedge clk);
            sent_words++;
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (queued != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (faults == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        int stall_pct;
        int phase_left;
        bit held_off;
        out_stall <= 1'b0;
        stall_pct  = 0;
        phase_left = 0;
        held_off   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && sent_words >= HOLD_OFF_AT)
            begin
                // hold off long enough for the block to back up into its input
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (sent_words < TOTAL_WORDS - QUIET_WORDS)
            begin
                if (phase_left == 0)
                begin
                    stall_pct  = $urandom_range(0, 1) ? 20 : 0;
                    phase_left = $urandom_range(50, 300);
                end
                phase_left--;
                if ($urandom_range(0, 99) < stall_pct)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

endmodule
